// File: rtl/core/cpu_clock_stepper_top_defines.svh
// Assertion macros used by the clock stepper sequencer.
`ifndef CPU_CLOCK_STEPPER_TOP_DEFINES_SVH
`define CPU_CLOCK_STEPPER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CCS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("clock stepper assertion failed");
`define CCS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("clock stepper assertion failed");
`else
`define CCS_ASSERT(lbl, clk, rst_n, prop)
`define CCS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: rtl/core/ccs_pkg.sv
// Types and constants shared by the clock stepper modules.
package ccs_pkg;

    localparam int unsigned CCS_STEP_COUNT = 6;
    localparam int unsigned NUM_STEP_LINES = 6;
    localparam int unsigned TIME_W         = 32;
    localparam int unsigned MS_CFG_W       = 10;

    localparam logic [MS_CFG_W-1:0] PERIOD_RESET   = 10'd1000;
    localparam logic [MS_CFG_W-1:0] DEBOUNCE_RESET = 10'd50;
    localparam logic [1:0]          PHASE_RESET    = 2'd3;
    localparam logic [1:0]          PHASE_STEP     = 2'd0;
    localparam logic [1:0]          PHASE_SET      = 2'd1;
    localparam logic [1:0]          PHASE_LOW      = 2'd3;

    typedef enum logic [1:0] {
        CFG_MANUAL_MODE = 2'd0,
        CFG_TICK_PERIOD = 2'd1,
        CFG_DEBOUNCE    = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              button_level;
        logic              hold;
    } t_in_item;

    typedef struct packed {
        logic                      ticked;
        logic                      clock_enable;
        logic                      clock_set;
        logic [NUM_STEP_LINES-1:0] step_lines;
        logic                      waiting_lamp;
    } t_out_item;

    typedef struct packed {
        logic                manual_mode;
        logic [MS_CFG_W-1:0] tick_period_ms;
        logic [MS_CFG_W-1:0] debounce_ms;
    } t_cfg;

    typedef struct packed {
        logic                      clock_enable;
        logic                      clock_set;
        logic [NUM_STEP_LINES-1:0] step_lines;
    } t_seq_view;

endpackage

// File: rtl/core/cpu_clock_stepper_top.sv
// Top level of the quarter tick clock generator with step counter.
//
// Input items carry a millisecond timestamp, the raw button level and a hold
// flag; each accepted item yields exactly one result item carrying the tick
// flag, both clock line levels, the one-hot step lines and the waiting lamp.
// Both channels use valid and ready; the configuration channel writes the
// mode, the tick period and the debounce time and is always ready.
// An accepted item is captured in an input register and is evaluated against
// the timer, debouncer and phase state once the output register is free or
// being read, when the result is loaded into the output register. One item is
// accepted every cycle while the receiver keeps ready high; the state update
// made while an item is evaluated is registered and used by the next item.
// When the receiver stalls the result waits in the output register while one
// further item is held in the input register; after that ready falls.
// Reset clears both stages, loads the register defaults (automatic mode,
// period 1000 ms, debounce 50 ms) and places the phase just before step
// phase zero with the clock lines low and no step line lit.
module cpu_clock_stepper_top
    import ccs_pkg::*;
#(
    parameter int unsigned STEP_COUNT = CCS_STEP_COUNT
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_item            i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [MS_CFG_W-1:0] i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in_data;
    logic      r_out_valid;
    t_out_item r_out_data;
    t_out_item n_out_data;

    t_cfg      w_cfg;
    t_seq_view w_view;
    logic      w_fire;
    logic      w_tick;

    assign w_fire      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_fire;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    ccs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    ccs_tick_gen u_tick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_in_data),
        .i_cfg   (w_cfg),
        .o_tick  (w_tick)
    );

    ccs_sequencer #(
        .STEP_COUNT (STEP_COUNT)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_tick  (w_tick),
        .o_view  (w_view)
    );

    always_comb begin
        n_out_data.ticked       = w_tick;
        n_out_data.clock_enable = w_view.clock_enable;
        n_out_data.clock_set    = w_view.clock_set;
        n_out_data.step_lines   = w_view.step_lines;
        n_out_data.waiting_lamp = r_in_data.hold || w_cfg.manual_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// File: rtl/core/ccs_cfg_regs.sv
// Configuration register file for the clock stepper.
module ccs_cfg_regs
    import ccs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [MS_CFG_W-1:0] i_cfg_data,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.manual_mode    <= 1'b0;
            r_cfg.tick_period_ms <= PERIOD_RESET;
            r_cfg.debounce_ms    <= DEBOUNCE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MANUAL_MODE: r_cfg.manual_mode    <= i_cfg_data[0];
                CFG_TICK_PERIOD: r_cfg.tick_period_ms <= i_cfg_data;
                CFG_DEBOUNCE:    r_cfg.debounce_ms    <= i_cfg_data;
                default:         r_cfg                <= r_cfg;
            endcase
        end
    end

endmodule

// File: rtl/core/ccs_tick_gen.sv
// Quarter tick decision: interval timer and button debouncer.
module ccs_tick_gen
    import ccs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    output logic     o_tick
);

    logic [TIME_W-1:0] r_last_tick;
    logic [TIME_W-1:0] r_last_change;
    logic              r_stable;
    logic              r_prev_raw;

    logic [TIME_W-1:0] n_last_tick;
    logic [TIME_W-1:0] n_last_change;
    logic              n_stable;
    logic              n_prev_raw;

    logic [TIME_W-1:0] w_tick_gap;
    logic [TIME_W-1:0] w_quiet_gap;
    logic              w_raw_changed;
    logic              w_timer_due;
    logic              w_settled;

    assign w_tick_gap    = i_item.now_ms - r_last_tick;
    assign w_quiet_gap   = i_item.now_ms - r_last_change;
    assign w_raw_changed = i_item.button_level != r_prev_raw;
    assign w_timer_due   = w_tick_gap >= {{(TIME_W-MS_CFG_W){1'b0}}, i_cfg.tick_period_ms};
    assign w_settled     = !w_raw_changed &&
                           (w_quiet_gap > {{(TIME_W-MS_CFG_W){1'b0}}, i_cfg.debounce_ms});

    always_comb begin
        n_last_tick   = r_last_tick;
        n_last_change = r_last_change;
        n_stable      = r_stable;
        n_prev_raw    = r_prev_raw;
        o_tick        = 1'b0;
        if (!i_item.hold) begin
            if (!i_cfg.manual_mode) begin
                if (w_timer_due) begin
                    o_tick      = 1'b1;
                    n_last_tick = i_item.now_ms;
                end
            end else begin
                if (w_raw_changed) begin
                    n_last_change = i_item.now_ms;
                end
                if (w_settled && (i_item.button_level != r_stable)) begin
                    n_stable = i_item.button_level;
                    o_tick   = i_item.button_level;
                end
                n_prev_raw = i_item.button_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_tick   <= '0;
            r_last_change <= '0;
            r_stable      <= 1'b1;
            r_prev_raw    <= 1'b1;
        end else if (i_fire) begin
            r_last_tick   <= n_last_tick;
            r_last_change <= n_last_change;
            r_stable      <= n_stable;
            r_prev_raw    <= n_prev_raw;
        end
    end

endmodule

// File: rtl/core/ccs_sequencer.sv
// Quarter phase and step counter with clock line and step line decode.
`include "cpu_clock_stepper_top_defines.svh"
module ccs_sequencer
    import ccs_pkg::*;
#(
    parameter int unsigned STEP_COUNT = CCS_STEP_COUNT
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  logic      i_tick,
    output t_seq_view o_view
);

    localparam int unsigned STEP_W = $clog2(STEP_COUNT + 1);

    logic [1:0]        r_phase;
    logic [STEP_W-1:0] r_step;
    logic [1:0]        n_phase;
    logic [STEP_W-1:0] n_step;
    logic              w_adv;

    assign w_adv = i_fire && i_tick;

    always_comb begin
        n_phase = r_phase;
        n_step  = r_step;
        if (w_adv) begin
            n_phase = r_phase + 2'd1;
            if (n_phase == PHASE_STEP) begin
                if (r_step >= STEP_W'(STEP_COUNT)) begin
                    n_step = STEP_W'(1);
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
        end
    end

    always_comb begin
        o_view.clock_enable = n_phase != PHASE_LOW;
        o_view.clock_set    = n_phase == PHASE_SET;
        for (int k = 0; k < NUM_STEP_LINES; k++) begin
            o_view.step_lines[k] = 32'(n_step) == 32'(k + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PHASE_RESET;
            r_step  <= '0;
        end else begin
            r_phase <= n_phase;
            r_step  <= n_step;
        end
    end

    `CCS_ASSERT(a_step_in_range, i_clk, i_rst_n, r_step <= STEP_W'(STEP_COUNT))
    `CCS_ASSERT(a_lines_onehot, i_clk, i_rst_n, $onehot0(o_view.step_lines))
    `CCS_ASSERT(a_phase_adv, i_clk, i_rst_n, w_adv |=> r_phase == $past(r_phase) + 2'd1)
    `CCS_ASSERT(a_hold_still, i_clk, i_rst_n, !w_adv |=> $stable(r_phase) && $stable(r_step))

endmodule

// File: bench/cpu_clock_stepper_top_tb.sv
// Self-checking testbench for the quarter tick clock generator with step counter.
`timescale 1ns / 1ps

module cpu_clock_stepper_top_tb;
    import ccs_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic                is_cfg;
        logic                manual;
        logic [MS_CFG_W-1:0] period;
        logic [MS_CFG_W-1:0] debounce;
        t_in_item            item;
        logic                pinned;
        t_out_item           want;
    } t_dir_row;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    t_in_item            i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b1;
    t_out_item           o_out_data;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index = '0;
    logic [MS_CFG_W-1:0] i_cfg_data = '0;

    logic      pin_on = 1'b0;
    t_out_item pin_val = '0;

    int unsigned send_gap_pct = 0;
    int unsigned ready_stall_pct = 0;
    logic        hold_off_req = 1'b0;
    int unsigned fail_cnt = 0;
    int unsigned cycle_cnt = 0;

    t_out_item pending_outs[$];

    logic                reg_manual;
    logic [MS_CFG_W-1:0] reg_period;
    logic [MS_CFG_W-1:0] reg_debounce;
    logic [1:0]          cur_phase;
    int unsigned         cur_step;
    logic [TIME_W-1:0]   tick_stamp;
    logic                btn_stable;
    logic                btn_prev;
    logic [TIME_W-1:0]   btn_change_at;
    logic                lvl_en;
    logic                lvl_set;

    cpu_clock_stepper_top u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void stepper_reset();
        reg_manual    = 1'b0;
        reg_period    = PERIOD_RESET;
        reg_debounce  = DEBOUNCE_RESET;
        cur_phase     = PHASE_RESET;
        cur_step      = 0;
        tick_stamp    = '0;
        btn_stable    = 1'b1;
        btn_prev      = 1'b1;
        btn_change_at = '0;
        lvl_en        = 1'b0;
        lvl_set       = 1'b0;
    endfunction

    function automatic void quarter_tick();
        cur_phase = cur_phase + 2'd1;
        lvl_en    = (cur_phase != PHASE_LOW);
        lvl_set   = (cur_phase == PHASE_SET);
        if (cur_phase == PHASE_STEP) begin
            cur_step = (cur_step >= CCS_STEP_COUNT) ? 1 : cur_step + 1;
        end
    endfunction

    function automatic t_out_item stepper_next(t_in_item it);
        t_out_item         res;
        logic [TIME_W-1:0] since;
        res = '0;
        res.waiting_lamp = it.hold | reg_manual;
        if (!it.hold) begin
            if (!reg_manual) begin
                since = it.now_ms - tick_stamp;
                if (since >= TIME_W'(reg_period)) begin
                    quarter_tick();
                    res.ticked = 1'b1;
                    tick_stamp = it.now_ms;
                end
            end else begin
                if (it.button_level != btn_prev) begin
                    btn_change_at = it.now_ms;
                end
                since = it.now_ms - btn_change_at;
                if (since > TIME_W'(reg_debounce) && it.button_level != btn_stable) begin
                    btn_stable = it.button_level;
                    if (it.button_level) begin
                        quarter_tick();
                        res.ticked = 1'b1;
                    end
                end
                btn_prev = it.button_level;
            end
        end
        res.clock_enable = lvl_en;
        res.clock_set    = lvl_set;
        if (cur_step >= 1 && cur_step <= NUM_STEP_LINES) begin
            res.step_lines[cur_step - 1] = 1'b1;
        end
        return res;
    endfunction

    function automatic t_dir_row row_cfg(logic manual, logic [MS_CFG_W-1:0] period,
                                         logic [MS_CFG_W-1:0] debounce);
        t_dir_row row;
        row          = '0;
        row.is_cfg   = 1'b1;
        row.manual   = manual;
        row.period   = period;
        row.debounce = debounce;
        return row;
    endfunction

    function automatic t_dir_row row_in(logic [TIME_W-1:0] now, logic btn, logic hold);
        t_dir_row row;
        row                   = '0;
        row.item.now_ms       = now;
        row.item.button_level = btn;
        row.item.hold         = hold;
        return row;
    endfunction

    function automatic t_dir_row row_chk(logic [TIME_W-1:0] now, logic btn, logic hold,
                                         t_out_item want);
        t_dir_row row;
        row        = row_in(now, btn, hold);
        row.pinned = 1'b1;
        row.want   = want;
        return row;
    endfunction

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_outs.size() != 0) @(negedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_index idx, logic [MS_CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        unique case (idx)
            CFG_MANUAL_MODE: reg_manual = val[0];
            CFG_TICK_PERIOD: reg_period = val;
            CFG_DEBOUNCE: reg_debounce = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_config(logic manual, logic [MS_CFG_W-1:0] period,
                              logic [MS_CFG_W-1:0] debounce);
        drain();
        cfg_write(CFG_MANUAL_MODE, {{(MS_CFG_W-1){1'b0}}, manual});
        cfg_write(CFG_TICK_PERIOD, period);
        cfg_write(CFG_DEBOUNCE, debounce);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic offer_item(t_in_item it, logic pinned, t_out_item want);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        pin_on     <= pinned;
        pin_val    <= want;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    function automatic logic [MS_CFG_W-1:0] pick_ms();
        unique case ($urandom_range(0, 5))
            0: return '0;
            1: return MS_CFG_W'(1);
            2: return MS_CFG_W'($urandom_range(2, 30));
            3: return MS_CFG_W'(1000);
            4: return '1;
            default: return MS_CFG_W'($urandom_range(0, 1023));
        endcase
    endfunction

    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= ready_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        t_out_item got;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                want = stepper_next(i_in_data);
                if (pin_on) begin
                    want = pin_val;
                end
                pending_outs.push_back(want);
            end
            if (o_out_valid && i_out_ready) begin
                got = o_out_data;
                if (pending_outs.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) begin
                        $display("unexpected result item: %p", got);
                    end
                end else begin
                    want = pending_outs.pop_front();
                    if (got.ticked !== want.ticked || got.clock_enable !== want.clock_enable ||
                        got.clock_set !== want.clock_set ||
                        got.step_lines !== want.step_lines ||
                        got.waiting_lamp !== want.waiting_lamp) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $display("mismatch: expected tick %b en %b set %b steps %b lamp %b",
                                     want.ticked, want.clock_enable, want.clock_set,
                                     want.step_lines, want.waiting_lamp);
                            $display("          actual   tick %b en %b set %b steps %b lamp %b",
                                     got.ticked, got.clock_enable, got.clock_set,
                                     got.step_lines, got.waiting_lamp);
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        t_dir_row          dir_tab[$];
        t_in_item          it;
        logic [TIME_W-1:0] stamp;
        logic              aim;
        int                bounce;
        int                ph;
        int                k;
        stepper_reset();
        aim    = 1'b1;
        bounce = 0;
        stamp  = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        dir_tab = '{
            row_chk(32'd0, 1'b1, 1'b0, t_out_item'{1'b0, 1'b0, 1'b0, 6'b000000, 1'b0}),
            row_chk(32'd999, 1'b1, 1'b0, t_out_item'{1'b0, 1'b0, 1'b0, 6'b000000, 1'b0}),
            row_chk(32'd1000, 1'b1, 1'b0, t_out_item'{1'b1, 1'b1, 1'b0, 6'b000001, 1'b0}),
            row_chk(32'd5000, 1'b0, 1'b1, t_out_item'{1'b0, 1'b1, 1'b0, 6'b000001, 1'b1}),
            row_chk(32'hFFFF_FFFF, 1'b1, 1'b0, t_out_item'{1'b1, 1'b1, 1'b1, 6'b000001, 1'b0}),
            row_chk(32'd999, 1'b1, 1'b0, t_out_item'{1'b1, 1'b1, 1'b0, 6'b000001, 1'b0}),
            row_chk(32'd1998, 1'b1, 1'b0, t_out_item'{1'b0, 1'b1, 1'b0, 6'b000001, 1'b0}),
            row_cfg(1'b0, 10'd0, 10'd50),
            row_chk(32'd1998, 1'b0, 1'b0, t_out_item'{1'b1, 1'b0, 1'b0, 6'b000001, 1'b0}),
            row_chk(32'd1998, 1'b1, 1'b0, t_out_item'{1'b1, 1'b1, 1'b0, 6'b000010, 1'b0}),
            row_chk(32'd1998, 1'b1, 1'b1, t_out_item'{1'b0, 1'b1, 1'b0, 6'b000010, 1'b1}),
            row_cfg(1'b0, 10'd1, 10'd50),
            row_chk(32'd1998, 1'b1, 1'b0, t_out_item'{1'b0, 1'b1, 1'b0, 6'b000010, 1'b0}),
            row_chk(32'd1999, 1'b1, 1'b0, t_out_item'{1'b1, 1'b1, 1'b1, 6'b000010, 1'b0}),
            row_cfg(1'b1, 10'd1000, 10'd0),
            row_in(32'd2000, 1'b0, 1'b0),
            row_in(32'd2001, 1'b0, 1'b0),
            row_in(32'd2002, 1'b1, 1'b0),
            row_in(32'd2003, 1'b1, 1'b0),
            row_in(32'd2004, 1'b0, 1'b1),
            row_cfg(1'b1, 10'd1000, 10'd1000),
            row_in(32'd2005, 1'b0, 1'b0),
            row_in(32'd3005, 1'b0, 1'b0),
            row_in(32'd3006, 1'b0, 1'b0),
            row_in(32'd3007, 1'b1, 1'b0),
            row_in(32'd3500, 1'b0, 1'b0),
            row_in(32'd3600, 1'b1, 1'b0),
            row_in(32'd4601, 1'b1, 1'b0),
            row_cfg(1'b0, 10'd1023, 10'd1023),
            row_in(32'd3022, 1'b1, 1'b0)
        };

        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg) begin
                set_config(dir_tab[i].manual, dir_tab[i].period, dir_tab[i].debounce);
            end else begin
                offer_item(dir_tab[i].item, dir_tab[i].pinned, dir_tab[i].want);
            end
        end
        stamp = 32'd3022;

        for (ph = 0; ph < 8; ph++) begin
            set_config(1'($urandom_range(0, 1)), pick_ms(), pick_ms());
            case (ph % 4)
                0: begin send_gap_pct = 0;  ready_stall_pct = 0;  end
                1: begin send_gap_pct = 68; ready_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  ready_stall_pct = 68; end
                default: begin send_gap_pct = 9; ready_stall_pct = 9; end
            endcase
            if (ph == 0) begin
                hold_off_req = 1'b1;
            end
            for (k = 0; k < 62; k++) begin
                if (ph == 4 && k == 31) begin
                    drain();
                end
                if ($urandom_range(0, 19) == 0) begin
                    stamp = $urandom();
                end else if (reg_manual) begin
                    stamp = stamp + $urandom_range(0, 32'(reg_debounce) / 3 + 1);
                end else begin
                    stamp = stamp + $urandom_range(0, 32'(reg_period) + 32'(reg_period) / 4 + 1);
                end
                if ($urandom_range(0, 9) == 0) begin
                    aim = ~aim;
                    bounce = $urandom_range(0, 3);
                end
                it.now_ms = stamp;
                it.button_level = aim;
                if (bounce > 0) begin
                    bounce--;
                    if ($urandom_range(0, 2) == 0) begin
                        it.button_level = ~aim;
                    end
                end
                if (!reg_manual || $urandom_range(0, 29) == 0) begin
                    it.button_level = 1'($urandom_range(0, 1));
                end
                it.hold = ($urandom_range(0, 9) == 0);
                offer_item(it, 1'b0, '0);
            end
        end

        send_gap_pct = 0;
        ready_stall_pct = 0;
        drain();
        repeat (8) @(negedge i_clk);
        if (fail_cnt == 0 && pending_outs.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/ccs_pkg.sv
rtl/core/ccs_cfg_regs.sv
rtl/core/ccs_tick_gen.sv
rtl/core/ccs_sequencer.sv
rtl/core/cpu_clock_stepper_top.sv
bench/cpu_clock_stepper_top_tb.sv
